// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/eldm_pkg.sv =====
`default_nettype none

package eldm_pkg;

	// Widths fixed by the transaction fields.
	localparam int POSITION_BITS = 16;
	localparam int ENERGY_BITS   = 16;
	localparam int STATE_BITS    = 32;
	// Two guard bits cover a state plus an energy and a state plus a state.
	localparam int WIDE_BITS     = STATE_BITS + 2;

	// Largest gap between one helix end and the next helix begin within a chain.
	localparam int CHAIN_GAP = 2;

	localparam logic signed [STATE_BITS-1:0] ENERGY_INFINITY = 32'sd10000000;

	// Depth of both queues.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	typedef logic signed [ENERGY_BITS-1:0] energy_t;
	typedef logic signed [STATE_BITS-1:0]  state_t;
	typedef logic signed [WIDE_BITS-1:0]   wide_t;

	// What the back end does with a helix.
	typedef enum logic [1:0] {
		OP_OPEN  = 2'd0,	// first helix of the loop: fresh chain, nothing to close
		OP_JOIN  = 2'd1,	// helix extends the current chain
		OP_BREAK = 2'd2,	// close the current chain, then start a new one
		OP_SKIP  = 2'd3		// later pseudoknot helix: no chain work
	} op_t;

	typedef struct packed {
		op_t     op;
		energy_t e_none;
		energy_t e_left;
		energy_t e_right;
		energy_t e_both;
		logic    last;
	} cmd_t;

	typedef struct packed {
		state_t total;
		logic   overflow;
	} result_t;

	function automatic wide_t widen_state(input state_t v);
		return {{(WIDE_BITS-STATE_BITS){v[STATE_BITS-1]}}, v};
	endfunction

	function automatic wide_t widen_energy(input energy_t v);
		return {{(WIDE_BITS-ENERGY_BITS){v[ENERGY_BITS-1]}}, v};
	endfunction

	function automatic wide_t min_wide(input wide_t a, input wide_t b);
		return (a < b) ? a : b;
	endfunction

	// Saturate a wide value to the signed state range.
	function automatic state_t sat_state(input wide_t v);
		state_t r;
		if (v[WIDE_BITS-1:STATE_BITS-1] == '0 || v[WIDE_BITS-1:STATE_BITS-1] == '1) begin
			r = v[STATE_BITS-1:0];
		end else if (v[WIDE_BITS-1]) begin
			r = {1'b1, {(STATE_BITS-1){1'b0}}};
		end else begin
			r = {1'b0, {(STATE_BITS-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/eldm_front.sv =====
`default_nettype none

module eldm_front (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                accept,
	input  wire logic [eldm_pkg::POSITION_BITS-1:0]  helix_begin,
	input  wire logic [eldm_pkg::POSITION_BITS-1:0]  helix_end,
	input  wire logic                                is_pseudoknot,
	input  wire eldm_pkg::energy_t                   energy_none,
	input  wire eldm_pkg::energy_t                   energy_left,
	input  wire eldm_pkg::energy_t                   energy_right,
	input  wire eldm_pkg::energy_t                   energy_both,
	input  wire logic                                last_helix,
	output eldm_pkg::cmd_t                           cmd
);
	import eldm_pkg::*;

	logic [POSITION_BITS-1:0] previous_end_q;
	logic                     first_seen_q;
	logic [POSITION_BITS-1:0] gap;
	logic                     joins;
	op_t                      op;

	// A helix joins the chain when it begins at most the chain gap past the previous end.
	assign gap   = helix_begin - previous_end_q;
	assign joins = (helix_begin >= previous_end_q) && (gap <= POSITION_BITS'(CHAIN_GAP));

	// Classify the helix.
	always_comb begin
		if (!first_seen_q) begin
			op = OP_OPEN;
		end else if (is_pseudoknot) begin
			op = OP_SKIP;
		end else if (joins) begin
			op = OP_JOIN;
		end else begin
			op = OP_BREAK;
		end
	end

	assign cmd = '{op: op, e_none: energy_none, e_left: energy_left,
		e_right: energy_right, e_both: energy_both, last: last_helix};

	// Every helix end becomes the previous end; the last helix re-arms the loop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			previous_end_q <= '0;
			first_seen_q   <= 1'b0;
		end else if (accept) begin
			previous_end_q <= helix_end;
			first_seen_q   <= !last_helix;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/eldm_cmd_queue.sv =====
`default_nettype none

module eldm_cmd_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_en,
	input  wire eldm_pkg::cmd_t wr_data,
	output logic                full,
	output logic                rd_valid,
	input  wire logic           rd_en,
	output eldm_pkg::cmd_t      rd_data
);
	import eldm_pkg::*;

	cmd_t                 slot_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;
	logic                 do_wr;
	logic                 do_rd;

	assign full     = (count_q == QCNT_BITS'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;
	assign rd_data  = slot_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage slots.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/eldm_back.sv =====
`default_nettype none

module eldm_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	input  wire eldm_pkg::cmd_t    cmd,
	output logic                   cmd_pop,
	input  wire logic              res_full,
	output logic                   res_push,
	output eldm_pkg::result_t      res_data
);
	import eldm_pkg::*;

	// Chain state.
	state_t free_q;
	state_t taken_q;
	state_t running_q;
	logic   error_q;

	// Final state of a loop, waiting for its total.
	logic   valid_s2;
	state_t free_s2;
	state_t taken_s2;
	state_t running_s2;
	logic   error_s2;

	logic   s2_ready;
	logic   advance;
	logic   opens;
	wide_t  base_free;
	wide_t  base_taken;
	wide_t  e0;
	wide_t  el;
	wide_t  er;
	wide_t  eb;
	wide_t  f_wide;
	wide_t  t_wide;
	logic   step_err;
	state_t closed_total;
	state_t free_nx;
	state_t taken_nx;
	state_t running_nx;
	logic   error_nx;

	// A loop's last helix waits until the total stage has room.
	assign s2_ready = !valid_s2 || !res_full;
	assign advance  = cmd_valid && (!cmd.last || s2_ready);
	assign cmd_pop  = advance;

	// A new chain starts from free at zero and taken at infinity.
	assign opens      = (cmd.op == OP_OPEN) || (cmd.op == OP_BREAK);
	assign base_free  = opens ? '0 : widen_state(free_q);
	assign base_taken = opens ? widen_state(ENERGY_INFINITY) : widen_state(taken_q);

	assign e0 = widen_energy(cmd.e_none);
	assign el = widen_energy(cmd.e_left);
	assign er = widen_energy(cmd.e_right);
	assign eb = widen_energy(cmd.e_both);

	// Two-state step of the chain.
	assign f_wide = min_wide(min_wide(base_free + e0, base_free + el), base_taken + e0);
	assign t_wide = min_wide(min_wide(base_free + el, base_free + er),
		min_wide(base_taken + er, base_free + eb));
	assign step_err = (f_wide > widen_state(ENERGY_INFINITY)) ||
		(t_wide > widen_state(ENERGY_INFINITY));

	// Closing a chain adds its better state to the running total.
	assign closed_total = sat_state(widen_state(running_q) +
		min_wide(widen_state(free_q), widen_state(taken_q)));

	always_comb begin
		unique case (cmd.op)
			OP_SKIP: begin
				free_nx    = free_q;
				taken_nx   = taken_q;
				running_nx = running_q;
				error_nx   = error_q;
			end
			OP_BREAK: begin
				free_nx    = sat_state(f_wide);
				taken_nx   = sat_state(t_wide);
				running_nx = closed_total;
				error_nx   = error_q || step_err;
			end
			default: begin
				free_nx    = sat_state(f_wide);
				taken_nx   = sat_state(t_wide);
				running_nx = running_q;
				error_nx   = error_q || step_err;
			end
		endcase
	end

	// The chain state returns to its reset values after the last helix.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q    <= '0;
			taken_q   <= ENERGY_INFINITY;
			running_q <= '0;
			error_q   <= 1'b0;
		end else if (advance) begin
			if (cmd.last) begin
				free_q    <= '0;
				taken_q   <= ENERGY_INFINITY;
				running_q <= '0;
				error_q   <= 1'b0;
			end else begin
				free_q    <= free_nx;
				taken_q   <= taken_nx;
				running_q <= running_nx;
				error_q   <= error_nx;
			end
		end
	end

	// Total stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= (advance && cmd.last) || (valid_s2 && !res_push);
		end
	end

	always_ff @(posedge clk) begin
		if (advance && cmd.last) begin
			free_s2    <= free_nx;
			taken_s2   <= taken_nx;
			running_s2 <= running_nx;
			error_s2   <= error_nx;
		end
	end

	// The loop total closes the final chain.
	assign res_push = valid_s2 && !res_full;
	assign res_data = '{total: sat_state(widen_state(running_s2) +
		min_wide(widen_state(free_s2), widen_state(taken_s2))), overflow: error_s2};

endmodule

`default_nettype wire

// ===== hw/rtl/eldm_result_queue.sv =====
`default_nettype none

module eldm_result_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire eldm_pkg::result_t wr_data,
	output logic                   full,
	output logic                   empty,
	input  wire logic              rd_en,
	output eldm_pkg::result_t      rd_data
);
	import eldm_pkg::*;

	result_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;
	logic                 do_wr;
	logic                 do_rd;

	assign full    = (count_q == QCNT_BITS'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage slots.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/exterior_loop_dangle_min_top.sv =====
`default_nettype none

// Exterior-loop dangle minimiser. Helices of one loop are pushed in 5' to 3' order, one
// transaction per helix, and the helix marked last yields one result transaction with the
// loop's minimum dangle energy and an overflow flag. One helix is taken every clock cycle
// while full is low; the chain update is one step of the two state registers in the back
// end. A result is registered in the helix queue, the total stage and the result queue
// before it is visible. Each side has a four-entry queue; full rises only when the helix
// queue fills, which happens only when the result queue backs up. No clearing is needed
// after reset.
module exterior_loop_dangle_min_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                push,
	output logic                                     full,
	input  wire logic [eldm_pkg::POSITION_BITS-1:0]  helix_begin,
	input  wire logic [eldm_pkg::POSITION_BITS-1:0]  helix_end,
	input  wire logic                                is_pseudoknot,
	input  wire eldm_pkg::energy_t                   energy_none,
	input  wire eldm_pkg::energy_t                   energy_left,
	input  wire eldm_pkg::energy_t                   energy_right,
	input  wire eldm_pkg::energy_t                   energy_both,
	input  wire logic                                last_helix,
	output logic                                     empty,
	input  wire logic                                pop,
	output eldm_pkg::state_t                         total_energy,
	output logic                                     overflow_error
);
	import eldm_pkg::*;

	logic    accept;
	cmd_t    cmd_in;
	logic    cmd_valid;
	cmd_t    cmd_head;
	logic    cmd_pop;
	logic    res_full;
	logic    res_push;
	result_t res_in;
	result_t res_head;

	assign accept = push && !full;

	// Front end: chain classification.
	eldm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.helix_begin  (helix_begin),
		.helix_end    (helix_end),
		.is_pseudoknot(is_pseudoknot),
		.energy_none  (energy_none),
		.energy_left  (energy_left),
		.energy_right (energy_right),
		.energy_both  (energy_both),
		.last_helix   (last_helix),
		.cmd          (cmd_in)
	);

	// Queue between the front and back ends.
	eldm_cmd_queue u_cmd_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (cmd_in),
		.full    (full),
		.rd_valid(cmd_valid),
		.rd_en   (cmd_pop),
		.rd_data (cmd_head)
	);

	// Back end: chain arithmetic and loop total.
	eldm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd_head),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res_data (res_in)
	);

	// Result queue towards the consumer.
	eldm_result_queue u_result_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_data(res_in),
		.full   (res_full),
		.empty  (empty),
		.rd_en  (pop),
		.rd_data(res_head)
	);

	assign total_energy   = res_head.total;
	assign overflow_error = res_head.overflow;

endmodule

`default_nettype wire

// ===== hw/rtl/eldm_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module eldm_checker (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire logic                   full,
	input  wire logic                   pop,
	input  wire logic                   empty,
	input  wire eldm_pkg::state_t       total_energy,
	input  wire logic                   overflow_error
);
	import eldm_pkg::*;

	// Both queues are clear while reset is held.
	`ASSERT_ALWAYS(a_reset_clear, clk, !arst_n |-> (empty && !full), "queues not clear in reset")

	// The helix queue can only fill through a transaction.
	`ASSERT_CLKD(a_full_after_push, clk, arst_n, $rose(full) |-> $past(push), "full rose without push")

	// The result queue can only drain through a transaction.
	`ASSERT_CLKD(a_empty_after_pop, clk, arst_n, $rose(empty) |-> $past(pop), "empty rose without pop")

	// A result that is not taken holds its value.
	`ASSERT_CLKD(a_result_hold, clk, arst_n, (!empty && !pop) |=> (!empty && $stable(total_energy) && $stable(overflow_error)), "waiting result changed")

endmodule

bind exterior_loop_dangle_min_top eldm_checker u_eldm_checker (.*);

`default_nettype wire
